/* design/pcsig_pkg.sv */
// pcsig_pkg: shared constants and control structs for the pc signature replacement core
// no dependencies

package pcsig_pkg;

    localparam int NUM_SETS  = 1024;
    localparam int NUM_WAYS  = 16;

    localparam int IN_SET_W  = 10;
    localparam int IN_WAY_W  = 4;
    localparam int PC_W      = 16;
    localparam int CNT_W     = 8;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int SIG_AW    = SET_W + WAY_W;
    localparam int SIG_DEPTH = NUM_SETS * NUM_WAYS;
    localparam int CNT_AW    = PC_W;
    localparam int CNT_DEPTH = 1 << PC_W;
    localparam int CLR_AW    = (SIG_AW > CNT_AW) ? SIG_AW : CNT_AW;

    localparam logic [CNT_W-1:0] CNT_CEIL = CNT_W'(255 - 1);

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } pcsig_op_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_issue;
        logic sig_wr;
        logic cnt_wr;
        logic out_load;
    } pcsig_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic scan_busy;
        logic out_free;
        logic hit;
    } pcsig_status_t;

endpackage

/* design/pcsig_ram.sv */
// pcsig_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module pcsig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/pcsig_ctrl.sv */
// pcsig_ctrl: sequencer for clear, victim scan and counter update
// depends on pcsig_pkg

module pcsig_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    operation,
    input  logic                    is_hit,
    input  logic                    is_writeback,
    input  pcsig_pkg::pcsig_status_t status,
    output pcsig_pkg::pcsig_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD_RD,
        ST_UPD_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                priority if (!in_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (operation == pcsig_pkg::OP_QUERY)
                begin
                    state_next = ST_SCAN;
                end
                else if (is_hit && is_writeback)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.scan_busy && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_UPD_RD:
            begin
                // fill stores the new signature
                cmd.sig_wr = !status.hit;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                cmd.cnt_wr = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/pcsig_datapath.sv */
// pcsig_datapath: signature and counter memories, scan pipeline, update logic, result word
// depends on pcsig_pkg and pcsig_ram

module pcsig_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcsig_pkg::pcsig_cmd_t               cmd,
    output pcsig_pkg::pcsig_status_t            status,
    input  logic [pcsig_pkg::IN_SET_W-1:0]      set_index,
    input  logic [pcsig_pkg::IN_WAY_W-1:0]      access_way,
    input  logic [pcsig_pkg::PC_W-1:0]          pc_low,
    input  logic                                is_hit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcsig_pkg::IN_WAY_W-1:0]      victim_way
);

    logic [pcsig_pkg::SET_W-1:0]  set_reg;
    logic [pcsig_pkg::WAY_W-1:0]  way_reg;
    logic [pcsig_pkg::PC_W-1:0]   pc_reg;
    logic                         hit_reg;

    logic [pcsig_pkg::CLR_AW-1:0] clr_addr_reg;
    logic [pcsig_pkg::WAY_W-1:0]  scan_way_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic [pcsig_pkg::WAY_W-1:0]  w1_reg;
    logic [pcsig_pkg::WAY_W-1:0]  w2_reg;
    logic [pcsig_pkg::CNT_W:0]    best_val_reg;
    logic [pcsig_pkg::WAY_W-1:0]  best_way_reg;
    logic                         out_valid_reg;
    logic [pcsig_pkg::IN_WAY_W-1:0] victim_reg;

    logic                         sig_we;
    logic [pcsig_pkg::SIG_AW-1:0] sig_waddr;
    logic [pcsig_pkg::PC_W-1:0]   sig_wdata;
    logic [pcsig_pkg::SIG_AW-1:0] sig_raddr;
    logic [pcsig_pkg::PC_W-1:0]   sig_rdata;

    logic                         cnt_we;
    logic [pcsig_pkg::CNT_AW-1:0] cnt_waddr;
    logic [pcsig_pkg::CNT_W-1:0]  cnt_wdata;
    logic [pcsig_pkg::CNT_AW-1:0] cnt_raddr;
    logic [pcsig_pkg::CNT_W-1:0]  cnt_rdata;
    logic [pcsig_pkg::CNT_W-1:0]  cnt_upd;

    logic                         clr_sig_en;
    logic                         clr_cnt_en;

    assign clr_sig_en = cmd.clr_step &&
        ({1'b0, clr_addr_reg} < (pcsig_pkg::CLR_AW + 1)'(pcsig_pkg::SIG_DEPTH));
    assign clr_cnt_en = cmd.clr_step &&
        ({1'b0, clr_addr_reg} < (pcsig_pkg::CLR_AW + 1)'(pcsig_pkg::CNT_DEPTH));

    always_comb
    begin
        priority if (hit_reg)
        begin
            cnt_upd = (cnt_rdata < pcsig_pkg::CNT_CEIL) ?
                      cnt_rdata + pcsig_pkg::CNT_W'(1) : cnt_rdata;
        end
        else
        begin
            cnt_upd = (cnt_rdata != '0) ? cnt_rdata - pcsig_pkg::CNT_W'(1) : cnt_rdata;
        end
    end

    assign sig_we    = clr_sig_en || cmd.sig_wr;
    assign sig_waddr = cmd.clr_step ? clr_addr_reg[pcsig_pkg::SIG_AW-1:0] : {set_reg, way_reg};
    assign sig_wdata = cmd.clr_step ? '0 : pc_reg;
    assign sig_raddr = {set_reg, scan_way_reg};

    assign cnt_we    = clr_cnt_en || cmd.cnt_wr;
    assign cnt_waddr = cmd.clr_step ? clr_addr_reg[pcsig_pkg::CNT_AW-1:0] : pc_reg;
    assign cnt_wdata = cmd.clr_step ? '0 : cnt_upd;
    assign cnt_raddr = v1_reg ? sig_rdata : pc_reg;

    pcsig_ram #(
        .WIDTH (pcsig_pkg::PC_W),
        .DEPTH (pcsig_pkg::SIG_DEPTH)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .raddr (sig_raddr),
        .rdata (sig_rdata)
    );

    pcsig_ram #(
        .WIDTH (pcsig_pkg::CNT_W),
        .DEPTH (pcsig_pkg::CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg      <= pcsig_pkg::SET_W'(set_index);
            way_reg      <= pcsig_pkg::WAY_W'(access_way);
            pc_reg       <= pc_low;
            hit_reg      <= is_hit;
            best_val_reg <= '1;
            best_way_reg <= '0;
        end
        else if (v2_reg && ({1'b0, cnt_rdata} <= best_val_reg))
        begin
            // ties go to the later way
            best_val_reg <= {1'b0, cnt_rdata};
            best_way_reg <= w2_reg;
        end
        w1_reg <= scan_way_reg;
        w2_reg <= w1_reg;
        if (cmd.out_load)
        begin
            victim_reg <= pcsig_pkg::IN_WAY_W'(best_way_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            scan_way_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + pcsig_pkg::CLR_AW'(1);
            end
            if (cmd.load)
            begin
                scan_way_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_way_reg <= scan_way_reg + pcsig_pkg::WAY_W'(1);
            end
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last  = &clr_addr_reg;
    assign status.scan_last = (scan_way_reg == pcsig_pkg::WAY_W'(pcsig_pkg::NUM_WAYS - 1));
    assign status.scan_busy = v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.hit       = hit_reg;

    assign out_valid  = out_valid_reg;
    assign victim_way = victim_reg;

    a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(v1_reg || v2_reg))
        else $error("result loaded while scan still in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_issue_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |=> v1_reg)
        else $error("scan read lost in pipeline");

    a_wr_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_wr || cmd.sig_wr) |-> !cmd.clr_step && !v1_reg)
        else $error("update write during clear or scan");

endmodule

/* design/pc_signature_cache_replacement_core.sv */
// pc_signature_cache_replacement_core: top level of the pc signature replacement policy
// depends on pcsig_pkg, pcsig_ctrl and pcsig_datapath

// After reset the core zeroes its counter and signature memories, one entry per cycle,
// stepping through the 65536 entries of the counter memory, and takes no word until that
// is done. A victim query makes one signature read per way, each feeding one read of the
// single counter memory port, and the result is loaded once the v1 and v2 pipeline stages
// have drained. A hit or fill update reads then writes the counter and gives no result;
// a writeback hit is dropped in the cycle it is accepted. The next word is taken while a
// query result still waits in the output register.

module pc_signature_cache_replacement_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [pcsig_pkg::IN_SET_W-1:0]     set_index,
    input  logic [pcsig_pkg::IN_WAY_W-1:0]     access_way,
    input  logic [pcsig_pkg::PC_W-1:0]         pc_low,
    input  logic                               is_hit,
    input  logic                               is_writeback,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pcsig_pkg::IN_WAY_W-1:0]     victim_way
);

    pcsig_pkg::pcsig_cmd_t    cmd;
    pcsig_pkg::pcsig_status_t status;

    pcsig_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .is_hit       (is_hit),
        .is_writeback (is_writeback),
        .status       (status),
        .cmd          (cmd)
    );

    pcsig_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .set_index  (set_index),
        .access_way (access_way),
        .pc_low     (pc_low),
        .is_hit     (is_hit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .victim_way (victim_way)
    );

endmodule
